### src/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder unit.
// ----------------------------------------------------------------------------
package u8u16_pkg;

   localparam int CountBits = 17;
   localparam int CapBits   = 17;
   localparam int CsrIdxBits = 2;

   typedef enum logic [CsrIdxBits-1:0] {
      CSR_CONVERT_LF      = 2'd0,
      CSR_CHECK_ENCODING  = 2'd1,
      CSR_BUFFER_CAPACITY = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_UNIT = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   localparam logic [7:0]  ByteCr       = 8'h0d;
   localparam logic [7:0]  ByteLf       = 8'h0a;
   localparam logic [15:0] UnitCr       = 16'h000d;
   // 0xd800 - (0x10000 >> 10)
   localparam logic [15:0] HiSurrBase   = 16'hd800 - 16'h0040;
   localparam logic [15:0] LoSurrBase   = 16'hdc00;

   // Work for one input byte: up to two code units, then maybe an end beat.
   typedef struct packed {
      logic [1:0]  n_units;
      logic [15:0] unit_a;
      logic [15:0] unit_b;
      logic        has_end;
      logic        err;
   } job_type;

endpackage

### src/u8u16_front.sv
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts UTF-8 bytes, tracks sequence state and builds one job per byte.
// ----------------------------------------------------------------------------
module u8u16_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   input  logic               req_last_byte,
   input  logic               convert_lf,
   input  logic               check_encoding,
   input  logic               queue_full,
   output logic               push,
   output u8u16_pkg::job_type push_job
);

   logic [1:0]  pending_ff,   pending_in;
   logic [1:0]  seq_len_ff,   seq_len_in;
   logic [20:0] collected_ff, collected_in;
   logic        prev_cr_ff,   prev_cr_in;
   logic        finished_ff,  finished_in;

   logic        accept;
   logic        err;
   logic        done;
   logic [20:0] cont_bits;
   logic [15:0] byte_unit;
   u8u16_pkg::job_type job;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign cont_bits = {collected_ff[14:0], req_in_byte[5:0]};
   assign byte_unit = {8'h00, req_in_byte};

   always_comb begin
      pending_in   = pending_ff;
      seq_len_in   = seq_len_ff;
      collected_in = collected_ff;
      prev_cr_in   = prev_cr_ff;
      finished_in  = finished_ff;
      err          = 1'b0;
      done         = 1'b0;
      job          = '0;

      if (!finished_ff) begin
         if (pending_ff != 2'd0) begin
            if (check_encoding && !req_in_byte[7]) begin
               err = 1'b1;
            end else begin
               collected_in = cont_bits;
               pending_in   = pending_ff - 2'd1;
               if (pending_ff == 2'd1) begin
                  if (seq_len_ff == 2'd3) begin
                     job.n_units = 2'd2;
                     job.unit_a  = u8u16_pkg::HiSurrBase + {5'b0, cont_bits[20:10]};
                     job.unit_b  = u8u16_pkg::LoSurrBase | {6'b0, cont_bits[9:0]};
                  end else begin
                     job.n_units = 2'd1;
                     job.unit_a  = cont_bits[15:0];
                  end
               end
            end
         end else if (req_in_byte == 8'h00) begin
            done = 1'b1;
         end else if (!req_in_byte[7]) begin
            if (convert_lf && req_in_byte == u8u16_pkg::ByteLf && !prev_cr_ff) begin
               job.n_units = 2'd2;
               job.unit_a  = u8u16_pkg::UnitCr;
               job.unit_b  = byte_unit;
            end else begin
               job.n_units = 2'd1;
               job.unit_a  = byte_unit;
            end
         end else if (req_in_byte[7:3] == 5'b11111) begin
            err = 1'b1;
         end else if (req_in_byte[7:3] == 5'b11110) begin
            seq_len_in   = 2'd3;
            pending_in   = 2'd3;
            collected_in = {18'b0, req_in_byte[2:0]};
         end else if (req_in_byte[7:4] == 4'b1110) begin
            seq_len_in   = 2'd2;
            pending_in   = 2'd2;
            collected_in = {17'b0, req_in_byte[3:0]};
         end else if (req_in_byte[7:5] == 3'b110) begin
            seq_len_in   = 2'd1;
            pending_in   = 2'd1;
            collected_in = {16'b0, req_in_byte[4:0]};
         end else begin
            err = 1'b1;   // stray continuation in lead position
         end

         if (!err && !done && req_last_byte) begin
            if (pending_in != 2'd0 && check_encoding) begin
               err = 1'b1;
            end else begin
               done = 1'b1;
            end
         end

         prev_cr_in = (req_in_byte == u8u16_pkg::ByteCr);

         if (err || done) begin
            finished_in  = 1'b1;
            pending_in   = 2'd0;
            seq_len_in   = 2'd0;
            collected_in = '0;
         end
         job.has_end = err || done;
         job.err     = err;
      end
   end

   assign push     = accept && (job.n_units != 2'd0 || job.has_end);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 2'd0;
         seq_len_ff   <= 2'd0;
         collected_ff <= '0;
         prev_cr_ff   <= 1'b0;
         finished_ff  <= 1'b0;
      end else if (accept) begin
         pending_ff   <= pending_in;
         seq_len_ff   <= seq_len_in;
         collected_ff <= collected_in;
         prev_cr_ff   <= prev_cr_in;
         finished_ff  <= finished_in;
      end
   end

endmodule

### src/u8u16_queue.sv
// ----------------------------------------------------------------------------
// u8u16_queue
// Two-entry job queue between the byte front end and the result back end.
// ----------------------------------------------------------------------------
module u8u16_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u8u16_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output u8u16_pkg::job_type head_job
);

   u8u16_pkg::job_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### src/u8u16_back.sv
// ----------------------------------------------------------------------------
// u8u16_back
// Expands queued jobs into result beats, numbers units, drives the output reg.
// ----------------------------------------------------------------------------
module u8u16_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  u8u16_pkg::job_type              head_job,
   output logic                            pop,
   input  logic [u8u16_pkg::CapBits-1:0]   buffer_capacity,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_kind,
   output logic [15:0]                     rsp_code_unit,
   output logic [u8u16_pkg::CountBits-1:0] rsp_unit_index,
   output logic                            rsp_in_buffer,
   output logic                            rsp_status,
   output logic                            rsp_run_last
);

   localparam int CB = u8u16_pkg::CountBits;

   logic [1:0]    step_ff,    step_in;
   logic [CB-1:0] counter_ff, counter_in;
   logic          valid_ff,   valid_in;
   logic          kind_ff,    kind_in;
   logic [15:0]   unit_ff,    unit_in;
   logic [CB-1:0] index_ff,   index_in;
   logic          inbuf_ff,   inbuf_in;
   logic          status_ff,  status_in;
   logic          last_ff,    last_in;

   logic          out_free;
   logic          load;
   logic [1:0]    total;
   logic          is_unit;

   assign out_free = !valid_ff || rsp_ready;
   assign load     = head_valid && out_free;
   assign total    = head_job.n_units + {1'b0, head_job.has_end};
   assign is_unit  = (step_ff < head_job.n_units);

   always_comb begin
      step_in    = step_ff;
      counter_in = counter_ff;
      valid_in   = valid_ff && !rsp_ready;
      kind_in    = kind_ff;
      unit_in    = unit_ff;
      index_in   = index_ff;
      status_in  = status_ff;
      last_in    = last_ff;
      pop        = 1'b0;

      if (load) begin
         valid_in = 1'b1;
         last_in  = (step_ff == total - 2'd1);
         if (is_unit) begin
            kind_in   = u8u16_pkg::KIND_UNIT;
            unit_in   = (step_ff == 2'd0) ? head_job.unit_a : head_job.unit_b;
            index_in  = counter_ff;
            status_in = 1'b0;
            if (counter_ff != {CB{1'b1}}) begin
               counter_in = counter_ff + {{(CB-1){1'b0}}, 1'b1};
            end
         end else begin
            kind_in   = u8u16_pkg::KIND_END;
            unit_in   = 16'h0000;
            status_in = head_job.err;
            index_in  = head_job.err ? '0 : counter_ff;
            if (head_job.err) begin
               counter_in = '0;
            end
         end
         if (last_in) begin
            pop     = 1'b1;
            step_in = 2'd0;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
      inbuf_in = load ? (index_in < buffer_capacity) : inbuf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= 2'd0;
         counter_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         step_ff    <= step_in;
         counter_ff <= counter_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      unit_ff   <= unit_in;
      index_ff  <= index_in;
      inbuf_ff  <= inbuf_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_code_unit  = unit_ff;
   assign rsp_unit_index = index_ff;
   assign rsp_in_buffer  = inbuf_ff;
   assign rsp_status     = status_ff;
   assign rsp_run_last   = last_ff;

endmodule

### src/utf8_to_utf16_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_unit
// Streaming UTF-8 to UTF-16 converter with LF expansion and unit numbering.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one UTF-8 byte per beat, req_last_byte marks the final byte.
//   rsp_*  : one beat per code unit, then one end beat (rsp_kind = 1) with
//            the unit count (0 on error), rsp_status and a zero terminator.
//            rsp_run_last flags the last beat caused by a given byte.
//   csr_*  : register writes (convert_lf, check_encoding, buffer_capacity),
//            taken at once; write only while the unit is idle.
// Path: a byte's first beat goes via the job queue entry, then the output reg.
// Throughput: one byte per cycle while rsp_ready holds and each byte gives
//   at most one beat. A byte giving more beats holds the result stage until
//   all are sent; the two-entry job queue absorbs this and req_ready drops
//   only when full.
// Reset clears decode state, the unit counter, the queue and the output
//   stage; registers return to convert_lf 0, check on, full capacity.
// A stalled rsp side backs up into the queue, then stalls req.
// After the end beat of a string further bytes are taken and dropped.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_in_byte,
   input  logic                                req_last_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_kind,
   output logic [15:0]                         rsp_code_unit,
   output logic [u8u16_pkg::CountBits-1:0]     rsp_unit_index,
   output logic                                rsp_in_buffer,
   output logic                                rsp_status,
   output logic                                rsp_run_last,
   input  logic                                csr_write_en,
   input  logic [u8u16_pkg::CsrIdxBits-1:0]    csr_index,
   input  logic [u8u16_pkg::CapBits-1:0]       csr_wdata
);

   logic                           convert_lf_ff;
   logic                           check_ff;
   logic [u8u16_pkg::CapBits-1:0]  capacity_ff;

   logic               push;
   logic               pop;
   logic               queue_full;
   logic               head_valid;
   u8u16_pkg::job_type push_job;
   u8u16_pkg::job_type head_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         convert_lf_ff <= 1'b0;
         check_ff      <= 1'b1;
         capacity_ff   <= {u8u16_pkg::CapBits{1'b1}};
      end else if (csr_write_en) begin
         unique case (csr_index)
            u8u16_pkg::CSR_CONVERT_LF:      convert_lf_ff <= csr_wdata[0];
            u8u16_pkg::CSR_CHECK_ENCODING:  check_ff      <= csr_wdata[0];
            u8u16_pkg::CSR_BUFFER_CAPACITY: capacity_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   u8u16_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_last_byte  (req_last_byte),
      .convert_lf     (convert_lf_ff),
      .check_encoding (check_ff),
      .queue_full     (queue_full),
      .push           (push),
      .push_job       (push_job)
   );

   u8u16_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   u8u16_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .buffer_capacity (capacity_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_code_unit   (rsp_code_unit),
      .rsp_unit_index  (rsp_unit_index),
      .rsp_in_buffer   (rsp_in_buffer),
      .rsp_status      (rsp_status),
      .rsp_run_last    (rsp_run_last)
   );

   // an end beat always closes the run of its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == u8u16_pkg::KIND_END |-> rsp_run_last)
      else $error("end beat without run_last");

   // an error end beat reports a zero count and a zero terminator
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_kind == u8u16_pkg::KIND_END &&
         rsp_unit_index == '0 && rsp_code_unit == 16'h0000)
      else $error("bad error beat");

   // a beat that is not last of its run is followed by a code unit or end
   // of the same run; never more than three beats per byte, so a non-last
   // beat cannot follow two non-last beats in a row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_run_last ##1
      rsp_valid && rsp_ready && !rsp_run_last |=>
      !(rsp_valid && !rsp_run_last))
      else $error("run longer than three beats");

endmodule
